// ===== sv/pgn_pkg.sv =====
// Package with shared constants and types for the gradient noise block.
`default_nettype none
package pgn_pkg;
    localparam int TABLE_ENTRIES_DEF    = 256;
    localparam int COORD_FRAC_BITS_DEF  = 16;
    localparam int RESULT_FRAC_BITS_DEF = 15;
    localparam int INV_SQRT2_BITS       = 24;
    localparam logic [24:0] INV_SQRT2_Q24 = 25'd11863283;
    localparam int OUT_W                = 16;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_EVAL = 1'b1
    } op_t;
endpackage
`default_nettype wire

// ===== sv/pgn_if.sv =====
// Valid/ready channel interfaces for the load/evaluate input and the noise result.
`default_nettype none
interface pgn_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [7:0]  table_index;
    logic [7:0]  table_value;
    logic signed [31:0] x_coord;
    logic signed [31:0] y_coord;
    modport source (output valid, op, table_index, table_value, x_coord, y_coord,
                    input ready);
    modport sink   (input valid, op, table_index, table_value, x_coord, y_coord,
                    output ready);
endinterface

interface pgn_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] noise_value;
    modport source (output valid, noise_value, input ready);
    modport sink   (input valid, noise_value, output ready);
endinterface
`default_nettype wire

// ===== sv/pgn_ram.sv =====
// Generic single write port memory with one registered read port.
`default_nettype none
module pgn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]              rd_data,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end
endmodule
`default_nettype wire

// ===== sv/pgn_fade.sv =====
// Pipelined quintic fade curve, one multiplication per register stage.
`default_nettype none
module pgn_fade
    import pgn_pkg::*;
#(
    parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         en,
    input  wire logic [COORD_FRAC_BITS-1:0]   t,
    output logic signed [COORD_FRAC_BITS+2:0] u
);
    localparam int F = COORD_FRAC_BITS;
    localparam int W = F + 6;
    localparam int PW = W + F + 2;

    logic [F-1:0] t1_reg, t2_reg, t3_reg;
    logic signed [W-1:0] b_reg, c_reg, d_reg;
    logic signed [PW-1:0] p1, p2, p3, p4;
    logic signed [W-1:0] six_t, fifteen, ten, lin;

    assign six_t   = W'(signed'({1'b0, t})) * W'(6);
    assign fifteen = W'(15) <<< F;
    assign ten     = W'(10) <<< F;
    assign lin     = six_t - fifteen;
    assign p1 = PW'(signed'({1'b0, t})) * PW'(lin);
    assign p2 = PW'(signed'({1'b0, t1_reg})) * PW'(b_reg);
    assign p3 = PW'(signed'({1'b0, t2_reg})) * PW'(c_reg);
    assign p4 = PW'(signed'({1'b0, t3_reg})) * PW'(d_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t1_reg <= t;
            b_reg  <= W'(p1 >>> F) + ten;
            t2_reg <= t1_reg;
            c_reg  <= W'(p2 >>> F);
            t3_reg <= t2_reg;
            d_reg  <= W'(p3 >>> F);
            u      <= (F + 3)'(p4 >>> F);
        end
    end
endmodule
`default_nettype wire

// ===== sv/perlin_gradient_noise_2d.sv =====
// Top level of the two-dimensional gradient noise pipeline.
// Usage: items arrive on the in channel. A load item (op = 0) writes one
// permutation table entry and produces no result. An evaluate item (op = 1)
// produces exactly one noise_value transfer on the out channel.
// The table holds no defined value after reset and must be loaded before
// any evaluate item reads an entry.
// Throughput is one item per cycle; the whole pipeline advances together as
// long as the final output register is free.
// Stage order: cell and fraction, first table lookups, second lookups,
// dot products, diagonal scaling, x blend multiply, x blend sum,
// y blend multiply, y blend sum, rescale and saturation. The fade curves
// run in parallel over four stages.
// Six table reads per item are served by six copies of the table, each
// written by every load transfer, so the table port sets no limit.
// When the receiver stalls, the pipeline freezes and nothing is lost.
// Reset clears all valid bits; the table contents are kept as undefined.
`default_nettype none
module perlin_gradient_noise_2d
    import pgn_pkg::*;
#(
    parameter int TABLE_ENTRIES    = TABLE_ENTRIES_DEF,
    parameter int COORD_FRAC_BITS  = COORD_FRAC_BITS_DEF,
    parameter int RESULT_FRAC_BITS = RESULT_FRAC_BITS_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    pgn_in_if.sink     in_ch,
    pgn_out_if.source  out_ch
);
    localparam int F  = COORD_FRAC_BITS;
    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int DW = F + 3;
    localparam int NS = 9;
    localparam int SW = DW + INV_SQRT2_BITS + 2;
    localparam int MW = 2 * DW + 2;
    localparam int ONE = 1 << F;

    logic adv;
    logic [NS-1:0] v_reg;
    logic load_now;
    logic [AW-1:0] wr_addr;

    assign adv         = !out_ch.valid || out_ch.ready;
    assign in_ch.ready = adv;
    assign load_now    = in_ch.valid && adv && (in_ch.op == OP_LOAD);
    assign wr_addr     = AW'(in_ch.table_index);

    // Stage 0: split coordinates.
    logic [AW-1:0] x0_s0, y0_s0;
    logic [F-1:0] fx_s0, fy_s0;
    logic [AW-1:0] x1_s0;
    assign x0_s0 = AW'(in_ch.x_coord >>> F);
    assign y0_s0 = AW'(in_ch.y_coord >>> F);
    assign x1_s0 = x0_s0 + AW'(1);
    assign fx_s0 = in_ch.x_coord[F-1:0];
    assign fy_s0 = in_ch.y_coord[F-1:0];

    logic [AW-1:0] y0_r1;
    logic [F-1:0] fx_r [1:2];
    logic [F-1:0] fy_r [1:2];
    logic [7:0] px0, px1;
    logic [7:0] h00, h10, h01, h11;

    pgn_ram #(.WIDTH(8), .DEPTH(TABLE_ENTRIES)) u_px0 (
        .clk, .rd_en(adv), .rd_addr(x0_s0), .rd_data(px0),
        .wr_en(load_now), .wr_addr, .wr_data(in_ch.table_value));
    pgn_ram #(.WIDTH(8), .DEPTH(TABLE_ENTRIES)) u_px1 (
        .clk, .rd_en(adv), .rd_addr(x1_s0), .rd_data(px1),
        .wr_en(load_now), .wr_addr, .wr_data(in_ch.table_value));

    logic [AW-1:0] a00, a10, a01, a11;
    assign a00 = AW'(px0) + y0_r1;
    assign a10 = AW'(px1) + y0_r1;
    assign a01 = AW'(px0) + y0_r1 + AW'(1);
    assign a11 = AW'(px1) + y0_r1 + AW'(1);

    pgn_ram #(.WIDTH(8), .DEPTH(TABLE_ENTRIES)) u_h00 (
        .clk, .rd_en(adv), .rd_addr(a00), .rd_data(h00),
        .wr_en(load_now), .wr_addr, .wr_data(in_ch.table_value));
    pgn_ram #(.WIDTH(8), .DEPTH(TABLE_ENTRIES)) u_h10 (
        .clk, .rd_en(adv), .rd_addr(a10), .rd_data(h10),
        .wr_en(load_now), .wr_addr, .wr_data(in_ch.table_value));
    pgn_ram #(.WIDTH(8), .DEPTH(TABLE_ENTRIES)) u_h01 (
        .clk, .rd_en(adv), .rd_addr(a01), .rd_data(h01),
        .wr_en(load_now), .wr_addr, .wr_data(in_ch.table_value));
    pgn_ram #(.WIDTH(8), .DEPTH(TABLE_ENTRIES)) u_h11 (
        .clk, .rd_en(adv), .rd_addr(a11), .rd_data(h11),
        .wr_en(load_now), .wr_addr, .wr_data(in_ch.table_value));

    // Fade curves: input at stage 0, result valid after four stages.
    logic signed [F+2:0] ux_s4, uy_s4;
    pgn_fade #(.COORD_FRAC_BITS(F)) u_fade_x (.clk, .en(adv), .t(fx_s0), .u(ux_s4));
    pgn_fade #(.COORD_FRAC_BITS(F)) u_fade_y (.clk, .en(adv), .t(fy_s0), .u(uy_s4));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            y0_r1    <= y0_s0;
            fx_r[1]  <= fx_s0;
            fy_r[1]  <= fy_s0;
            fx_r[2]  <= fx_r[1];
            fy_r[2]  <= fy_r[1];
        end
    end

    // Stage 3: gradient selection; hashes and offsets arrive at stage 2 output.
    function automatic logic signed [DW-1:0] pick(input logic [2:0] h,
                                                  input logic signed [DW-1:0] dx,
                                                  input logic signed [DW-1:0] dy);
        logic signed [DW-1:0] r;
        case (h)
            3'd0:    r = dx;
            3'd1:    r = -dx;
            3'd2:    r = dy;
            3'd3:    r = -dy;
            3'd4:    r = dx + dy;
            3'd5:    r = dy - dx;
            3'd6:    r = dx - dy;
            default: r = -dx - dy;
        endcase
        return r;
    endfunction

    logic signed [DW-1:0] dx0, dx1, dy0, dy1;
    assign dx0 = DW'(signed'({1'b0, fx_r[2]}));
    assign dy0 = DW'(signed'({1'b0, fy_r[2]}));
    assign dx1 = dx0 - DW'(ONE);
    assign dy1 = dy0 - DW'(ONE);

    logic signed [DW-1:0] s_reg [4];
    logic [3:0] diag_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s_reg[0] <= pick(h00[2:0], dx0, dy0);
            s_reg[1] <= pick(h10[2:0], dx1, dy0);
            s_reg[2] <= pick(h01[2:0], dx0, dy1);
            s_reg[3] <= pick(h11[2:0], dx1, dy1);
            diag_reg <= {h11[2], h01[2], h10[2], h00[2]};
        end
    end

    // Stage 4: diagonal scaling.
    logic signed [DW-1:0] d_reg [4];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 4; i++)
            begin
                if (diag_reg[i])
                begin
                    d_reg[i] <= DW'((SW'(s_reg[i]) * SW'(signed'(INV_SQRT2_Q24)))
                                    >>> INV_SQRT2_BITS);
                end
                else
                begin
                    d_reg[i] <= s_reg[i];
                end
            end
        end
    end

    // Fade outputs align with stage 4 results; stage 5: x blend products.
    logic signed [F+2:0] uy_r5, uy_r6;
    logic signed [DW-1:0] lo_a_reg, hi_a_reg;
    logic signed [MW-1:0] lo_p_reg, hi_p_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lo_a_reg <= d_reg[0];
            hi_a_reg <= d_reg[2];
            lo_p_reg <= MW'(d_reg[1] - d_reg[0]) * MW'(ux_s4);
            hi_p_reg <= MW'(d_reg[3] - d_reg[2]) * MW'(ux_s4);
            uy_r5    <= uy_s4;
        end
    end

    // Stage 6: x blend sums.
    logic signed [DW-1:0] lo_reg, hi_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lo_reg <= lo_a_reg + DW'(lo_p_reg >>> F);
            hi_reg <= hi_a_reg + DW'(hi_p_reg >>> F);
            uy_r6  <= uy_r5;
        end
    end

    // Stage 7: y blend product; stage 8: sum; stage 9: rescale and clamp.
    logic signed [DW-1:0] lo_r7;
    logic signed [MW-1:0] y_p_reg;
    logic signed [DW-1:0] r_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lo_r7   <= lo_reg;
            y_p_reg <= MW'(hi_reg - lo_reg) * MW'(uy_r6);
            r_reg   <= lo_r7 + DW'(y_p_reg >>> F);
        end
    end

    localparam int RW = DW + 26;
    localparam int TOPV = (RESULT_FRAC_BITS >= 15) ? 32767 : ((1 << RESULT_FRAC_BITS) - 1);
    localparam int BOTV = (RESULT_FRAC_BITS >= 15) ? -32768 : -(1 << RESULT_FRAC_BITS);
    logic signed [RW-1:0] rs;
    logic signed [OUT_W-1:0] sat;
    always_comb
    begin
        if (RESULT_FRAC_BITS >= F)
        begin
            rs = RW'(r_reg) <<< (RESULT_FRAC_BITS - F);
        end
        else
        begin
            rs = RW'(r_reg) >>> (F - RESULT_FRAC_BITS);
        end
        if (rs > RW'(TOPV))
        begin
            sat = OUT_W'(TOPV);
        end
        else if (rs < RW'(BOTV))
        begin
            sat = OUT_W'(BOTV);
        end
        else
        begin
            sat = OUT_W'(rs);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_ch.noise_value <= sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[NS-2:0], in_ch.valid && (in_ch.op == OP_EVAL)};
        end
    end
    assign out_ch.valid = v_reg[NS-1];

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.noise_value))
        else $error("result changed while stalled");
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(v_reg))
        else $error("pipeline moved while stalled");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_ch.valid |-> in_ch.ready)
        else $error("input blocked with empty output");
endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the two-dimensional gradient noise block.
`default_nettype none
module tb;
    import pgn_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_RANDOM = 1260;

    typedef struct {
        op_t         op;
        logic [7:0]  idx;
        logic [7:0]  val;
        logic [31:0] x;
        logic [31:0] y;
        logic        has_exp;
        logic [15:0] exp_val;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    pgn_in_if  in_ch();
    pgn_out_if out_ch();

    perlin_gradient_noise_2d dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    logic [7:0]  perm_copy [256];
    logic [15:0] noise_queue [$];
    int          errors = 0;
    int          evals_sent = 0;
    int          loads_sent = 0;
    int          results_seen = 0;
    stim_row_t   directed [$];

    function automatic longint floor_div(longint p, int s);
        longint mag;
        if (p >= 0)
            return p >>> s;
        mag = -p;
        return -((mag + ((64'sd1 <<< s) - 1)) >>> s);
    endfunction

    function automatic longint fixmul(longint a, longint b);
        return floor_div(a * b, 16);
    endfunction

    function automatic longint fade_curve(longint t);
        longint u;
        u = 6 * t - 15 * 65536;
        u = fixmul(t, u) + 10 * 65536;
        u = fixmul(t, u);
        u = fixmul(t, u);
        return fixmul(t, u);
    endfunction

    function automatic longint corner_dot(logic [7:0] h, longint dx, longint dy);
        longint s;
        case (h[2:0])
            3'd0: return dx;
            3'd1: return -dx;
            3'd2: return dy;
            3'd3: return -dy;
            3'd4: s = dx + dy;
            3'd5: s = -dx + dy;
            3'd6: s = dx - dy;
            default: s = -dx - dy;
        endcase
        return floor_div(s * longint'(INV_SQRT2_Q24), INV_SQRT2_BITS);
    endfunction

    function automatic logic [15:0] noise_at(logic [31:0] xr, logic [31:0] yr);
        logic [7:0] x0, y0, x1, y1, px0, px1, h00, h10, h01, h11;
        longint fx, fy, d00, d10, d01, d11, ux, uy, lo, hi, r;
        x0 = xr[23:16];
        y0 = yr[23:16];
        fx = longint'(xr[15:0]);
        fy = longint'(yr[15:0]);
        x1 = x0 + 8'd1;
        y1 = y0 + 8'd1;
        px0 = perm_copy[x0];
        px1 = perm_copy[x1];
        h00 = perm_copy[8'(px0 + y0)];
        h10 = perm_copy[8'(px1 + y0)];
        h01 = perm_copy[8'(px0 + y1)];
        h11 = perm_copy[8'(px1 + y1)];
        d00 = corner_dot(h00, fx, fy);
        d10 = corner_dot(h10, fx - 65536, fy);
        d01 = corner_dot(h01, fx, fy - 65536);
        d11 = corner_dot(h11, fx - 65536, fy - 65536);
        ux = fade_curve(fx);
        uy = fade_curve(fy);
        lo = d00 + fixmul(d10 - d00, ux);
        hi = d01 + fixmul(d11 - d01, ux);
        r = lo + fixmul(hi - lo, uy);
        r = floor_div(r, 1);
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r[15:0];
    endfunction

    function automatic stim_row_t load_row(logic [7:0] i, logic [7:0] v);
        stim_row_t s;
        s = '{OP_LOAD, i, v, 32'h0, 32'h0, 1'b0, 16'h0};
        return s;
    endfunction

    function automatic stim_row_t eval_row(logic [31:0] x, logic [31:0] y,
                                          logic has, logic [15:0] e);
        stim_row_t s;
        s = '{OP_EVAL, 8'h0, 8'h0, x, y, has, e};
        return s;
    endfunction

    task automatic send_item(stim_row_t s);
        logic [15:0] e;
        while ($urandom_range(0, 7) == 0)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.op <= s.op;
        in_ch.table_index <= s.idx;
        in_ch.table_value <= s.val;
        in_ch.x_coord <= s.x;
        in_ch.y_coord <= s.y;
        do
            @(posedge clk);
        while (!in_ch.ready);
        if (s.op == OP_LOAD)
        begin
            perm_copy[s.idx] = s.val;
            loads_sent++;
        end
        else
        begin
            e = noise_at(s.x, s.y);
            if (s.has_exp && e !== s.exp_val)
            begin
                $display("%0t predictor disagrees with table: expected %h actual %h",
                         $realtime, s.exp_val, e);
                errors++;
            end
            noise_queue.push_back(s.has_exp ? s.exp_val : e);
            evals_sent++;
        end
        @(negedge clk);
        if ($urandom_range(0, 3) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            results_seen++;
            if (noise_queue.size() == 0)
            begin
                $display("%0t unexpected noise transfer: actual %h", $realtime,
                         out_ch.noise_value);
                errors++;
            end
            else if (noise_queue[0] !== out_ch.noise_value)
            begin
                $display("%0t noise mismatch: expected %h actual %h", $realtime,
                         noise_queue[0], out_ch.noise_value);
                errors++;
                void'(noise_queue.pop_front());
            end
            else
                void'(noise_queue.pop_front());
        end
    end

    initial
    begin
        int phase;
        out_ch.ready = 1'b0;
        phase = 0;
        forever
        begin
            @(negedge clk);
            phase++;
            if (phase % 400 < 100)
                out_ch.ready <= 1'b1;
            else
                out_ch.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    initial
    begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        logic [31:0] xr, yr;
        int burst;
        in_ch.valid = 1'b0;
        in_ch.op = OP_LOAD;
        in_ch.table_index = 8'h0;
        in_ch.table_value = 8'h0;
        in_ch.x_coord = 32'h0;
        in_ch.y_coord = 32'h0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // All-zero table: every hash picks the +x gradient, so integer points give zero.
        for (int i = 0; i < 256; i++)
            send_item(load_row(8'(i), 8'h00));
        directed.push_back(eval_row(32'h0000_0000, 32'h0000_0000, 1'b1, 16'h0000));
        directed.push_back(eval_row(32'h7FFF_0000, 32'h8000_0000, 1'b1, 16'h0000));
        directed.push_back(eval_row(32'hFFFF_0000, 32'hFFFF_0000, 1'b1, 16'h0000));
        directed.push_back(eval_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 16'h0));
        directed.push_back(eval_row(32'h8000_0000, 32'hFFFF_FFFF, 1'b0, 16'h0));
        directed.push_back(eval_row(32'h0000_8000, 32'h0000_8000, 1'b0, 16'h0));
        directed.push_back(load_row(8'hFF, 8'hFF));
        directed.push_back(load_row(8'h00, 8'h07));
        directed.push_back(load_row(8'h01, 8'h05));
        directed.push_back(eval_row(32'h00FF_4000, 32'h00FF_C000, 1'b0, 16'h0));
        directed.push_back(eval_row(32'hFFFF_8000, 32'h0001_2000, 1'b0, 16'h0));
        for (int g = 0; g < 8; g++)
        begin
            directed.push_back(load_row(8'h02, 8'(g)));
            directed.push_back(eval_row(32'h0002_C000, 32'hFF00_3000, 1'b0, 16'h0));
        end
        foreach (directed[i])
            send_item(directed[i]);

        // Random table contents, then mostly evaluations with some reloads.
        for (int i = 0; i < 256; i++)
            send_item(load_row(8'(i), 8'($urandom)));
        burst = 0;
        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_item(load_row(8'($urandom), 8'($urandom)));
            else
            begin
                xr = $urandom;
                yr = $urandom;
                if ($urandom_range(0, 4) == 0) xr[15:0] = $urandom_range(0, 1) ? 16'h0 : 16'hFFFF;
                if ($urandom_range(0, 4) == 0) yr[15:0] = $urandom_range(0, 1) ? 16'h0 : 16'hFFFF;
                send_item(eval_row(xr, yr, 1'b0, 16'h0));
            end
            burst++;
            if (burst > $urandom_range(4, 40))
            begin
                burst = 0;
                in_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 20)) @(negedge clk);
            end
        end
        in_ch.valid <= 1'b0;

        while (noise_queue.size() != 0)
            @(negedge clk);
        repeat (30) @(negedge clk);

        $display("Sent %0d table loads and %0d noise evaluations; %0d results checked.",
                 loads_sent, evals_sent, results_seen);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
`default_nettype wire
